// ----- hdl/swma_pkg.sv -----
// swma_pkg: command and status codes, result constants and the
// controller/datapath command and status structs of the middle-access stack.
// No dependencies.
package swma_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    OP_DONE  = 2'd0,
    OP_FULL  = 2'd1,
    OP_EMPTY = 2'd2
  } op_status_t;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;
  localparam logic signed [VALUE_W-1:0] EMPTY_MIDDLE = -32'sd1;

  // controller to datapath
  typedef struct packed {
    logic       push_we;   // write pushed value on top, count up
    logic       occ_dec;   // count down
    logic       idx_load;  // shift index starts at the middle
    logic       shift_rd;  // read the cell above the shift index
    logic       shift_wr;  // move that cell down one place
    logic       mid_rd;    // read the middle cell
    logic       out_load;  // load the result register
    op_status_t status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic occ_zero;
    logic occ_full;
    logic shift_more;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- hdl/swma_if.sv -----
// swma_if: valid/ready channels for requests and results of the stack.
// Depends on swma_pkg.
interface swma_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             command;
  logic signed [swma_pkg::VALUE_W-1:0]    push_value;

  modport source (output valid, output command, output push_value, input ready);
  modport sink   (input valid, input command, input push_value, output ready);
endinterface

interface swma_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [swma_pkg::VALUE_W-1:0]    middle_value;
  logic [swma_pkg::COUNT_W-1:0]           entry_count;
  logic [1:0]                             op_status;

  modport source (output valid, output middle_value, output entry_count,
                  output op_status, input ready);
  modport sink   (input valid, input middle_value, input entry_count,
                  input op_status, output ready);
endinterface

// ----- hdl/swma_ctrl.sv -----
// swma_ctrl: sequencer for one request at a time (accept, shift loop,
// middle read, result load). Depends on swma_pkg.
module swma_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_command,
  output logic               in_ready,
  input  swma_pkg::dp_stat_t stat,
  output swma_pkg::dp_cmd_t  cmd
);
  import swma_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_SHIFT_RD = 5'b00010,
    S_SHIFT_WR = 5'b00100,
    S_READ     = 5'b01000,
    S_RESP     = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  op_status_t status_r, status_nxt;

  // next state and datapath commands
  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd        = '0;
    cmd.status = status_r;
    in_ready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          status_nxt = OP_DONE;
          state_nxt  = S_READ;
          case (cmd_code_t'(in_command))
            CMD_PUSH: begin
              if (stat.occ_full) status_nxt = OP_FULL;
              else cmd.push_we = 1'b1;
            end
            CMD_POP: begin
              if (stat.occ_zero) status_nxt = OP_EMPTY;
              else cmd.occ_dec = 1'b1;
            end
            CMD_DELETE: begin
              if (stat.occ_zero) begin
                status_nxt = OP_EMPTY;
              end else begin
                cmd.idx_load = 1'b1;
                state_nxt    = S_SHIFT_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_SHIFT_RD: begin
        if (stat.shift_more) begin
          cmd.shift_rd = 1'b1;
          state_nxt    = S_SHIFT_WR;
        end else begin
          cmd.occ_dec = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = S_SHIFT_RD;
      end
      S_READ: begin
        cmd.mid_rd = 1'b1;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= OP_DONE;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  // a shift move is always a read followed by its write
  a_shift_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift_rd |=> cmd.shift_wr)
    else $error("shift read not followed by write");

  // a result is only loaded after the middle cell was read
  a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (state_r == S_RESP))
    else $error("result loaded outside response step");

  // requests are taken only with no shift in progress
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.shift_rd || cmd.shift_wr || cmd.mid_rd) |-> !in_ready)
    else $error("request taken while busy");

endmodule

// ----- hdl/swma_dp.sv -----
// swma_dp: entry memory, occupancy and shift index registers and the
// result register. Depends on swma_pkg.
module swma_dp #(
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic signed [swma_pkg::VALUE_W-1:0]  push_value,
  input  swma_pkg::dp_cmd_t                    cmd,
  output swma_pkg::dp_stat_t                   stat,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [swma_pkg::VALUE_W-1:0]  out_middle,
  output logic [swma_pkg::COUNT_W-1:0]         out_count,
  output logic [1:0]                           out_status
);
  import swma_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [VALUE_W-1:0] mem [DEPTH];
  logic signed [VALUE_W-1:0] rd_r;
  logic [CW-1:0]             occ_r, occ_nxt;
  logic [AW-1:0]             idx_r;
  logic [CW-1:0]             half_occ;
  logic [CW:0]               idx_up;
  logic [AW-1:0]             rd_addr, wr_addr;
  logic                      we;
  logic signed [VALUE_W-1:0] wr_data;
  logic [CW+COUNT_W-1:0]     occ_ext;
  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] out_middle_r;
  logic [COUNT_W-1:0]        out_count_r;
  logic [1:0]                out_status_r;

  assign half_occ = occ_r >> 1;
  assign idx_up   = {{(CW + 1 - AW){1'b0}}, idx_r} + {{CW{1'b0}}, 1'b1};

  // status towards the controller
  assign stat.occ_zero   = (occ_r == '0);
  assign stat.occ_full   = (occ_r == CW'(DEPTH));
  assign stat.shift_more = (idx_up < {1'b0, occ_r});
  assign stat.out_free   = !out_valid_r || out_ready;

  // memory port selection
  assign rd_addr = cmd.shift_rd ? idx_up[AW-1:0] : half_occ[AW-1:0];
  assign we      = cmd.push_we || cmd.shift_wr;
  assign wr_addr = cmd.push_we ? occ_r[AW-1:0] : idx_r;
  assign wr_data = cmd.push_we ? push_value : rd_r;

  // entry memory
  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_rd || cmd.mid_rd) rd_r <= mem[rd_addr];
  end

  // occupancy and shift index
  always_comb begin
    occ_nxt = occ_r;
    if (cmd.push_we)      occ_nxt = occ_r + CW'(1);
    else if (cmd.occ_dec) occ_nxt = occ_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) occ_r <= '0;
    else occ_r <= occ_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_load)      idx_r <= half_occ[AW-1:0];
    else if (cmd.shift_wr) idx_r <= idx_up[AW-1:0];
  end

  // result register
  assign occ_ext = {{COUNT_W{1'b0}}, occ_r};

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_middle_r <= stat.occ_zero ? EMPTY_MIDDLE : rd_r;
      out_count_r  <= occ_ext[COUNT_W-1:0];
      out_status_r <= cmd.status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_middle = out_middle_r;
  assign out_count  = out_count_r;
  assign out_status = out_status_r;

  // occupancy never passes the depth
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(DEPTH))
    else $error("occupancy beyond depth");

  // no push into a full stack and no pop of an empty one
  a_occ_legal: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.push_we && stat.occ_full) && !(cmd.occ_dec && stat.occ_zero))
    else $error("illegal occupancy update");

  // shift writes stay below the top entry
  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift_wr |-> (idx_up < {1'b0, occ_r}))
    else $error("shift write out of range");

endmodule

// ----- hdl/stack_with_middle_access.sv -----
// stack_with_middle_access: top level of a bounded stack that also reports
// and deletes its middle entry. Depends on swma_pkg, swma_if, swma_ctrl, swma_dp.
//
//   channel   direction  payload                                   handshake
//   in_req    in         command, push_value                       valid/ready
//   out_rsp   out        middle_value, entry_count, op_status      valid/ready
//
// Push, pop and find middle go through accept, middle read from the entry
// memory and result load. Delete middle adds a move for each of the m entries
// above the middle before the middle read, as each move is a memory read then
// a write. Reset (rst_n, synchronous) empties the stack at once; cell contents
// are not cleared. A stalled result holds in the output register; a new
// request is accepted while it waits.
module stack_with_middle_access #(
  parameter int DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  swma_req_if.sink   in_req,
  swma_rsp_if.source out_rsp
);
  import swma_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     ready;

  swma_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_req.valid),
    .in_command (in_req.command),
    .in_ready   (ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  swma_dp #(.DEPTH(DEPTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_value (in_req.push_value),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (out_rsp.ready),
    .out_valid  (out_rsp.valid),
    .out_middle (out_rsp.middle_value),
    .out_count  (out_rsp.entry_count),
    .out_status (out_rsp.op_status)
  );

  assign in_req.ready = ready;

endmodule

// ----- tb/stack_with_middle_access_test.sv -----
`timescale 1ns / 1ps
// stack_with_middle_access_test: self-checking bench for the middle-access stack,
// with a shadow stack predicting every reply, bursty requests and a stalling receiver.
// Depends on swma_pkg, swma_if and stack_with_middle_access.
module stack_with_middle_access_test;
  import swma_pkg::*;

  localparam int STACK_DEPTH   = 64;
  localparam int RANDOM_ITEMS  = 1000;
  localparam int IDLE_LIMIT    = 4000;
  // longest operation is a delete from a full stack
  localparam int SETTLE_CYCLES = 4 + 2 * STACK_DEPTH;
  localparam int REPORT_LIMIT  = 40;

  typedef struct {
    logic signed [VALUE_W-1:0] middle;
    logic [COUNT_W-1:0]        count;
    op_status_t                status;
  } stack_reply_t;

  typedef enum int {TREND_GROW, TREND_SHRINK, TREND_MIXED} fill_trend_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  swma_req_if req_ch ();
  swma_rsp_if rsp_ch ();

  stack_with_middle_access #(
    .DEPTH(STACK_DEPTH)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch),
    .out_rsp(rsp_ch)
  );

  // shadow copy of the stack and the replies still owed by the block
  logic signed [VALUE_W-1:0] shadow_cells [STACK_DEPTH];
  int                        shadow_fill = 0;
  stack_reply_t              expected_replies [$];

  int error_count   = 0;
  int checked_count = 0;
  int sent_count    = 0;
  int push_count    = 0;
  int pop_count     = 0;
  int find_count    = 0;
  int delete_count  = 0;
  int full_drops    = 0;
  int empty_ignores = 0;
  int stalled_cycles = 0;

  bit sender_bursty = 1'b1;
  int burst_left    = 0;

  // apply one request to the shadow stack and work out its reply
  function automatic stack_reply_t predict_reply(input cmd_code_t cmd,
                                                 input logic signed [VALUE_W-1:0] val);
    stack_reply_t reply;
    reply.status = OP_DONE;
    case (cmd)
      CMD_PUSH: begin
        push_count++;
        if (shadow_fill >= STACK_DEPTH) begin
          reply.status = OP_FULL;
          full_drops++;
        end else begin
          shadow_cells[shadow_fill] = val;
          shadow_fill++;
        end
      end
      CMD_POP: begin
        pop_count++;
        if (shadow_fill == 0) begin
          reply.status = OP_EMPTY;
          empty_ignores++;
        end else begin
          shadow_fill--;
        end
      end
      CMD_DELETE: begin
        delete_count++;
        if (shadow_fill == 0) begin
          reply.status = OP_EMPTY;
          empty_ignores++;
        end else begin
          // entries above the middle close the gap
          for (int i = shadow_fill / 2; i + 1 < shadow_fill; i++)
            shadow_cells[i] = shadow_cells[i + 1];
          shadow_fill--;
        end
      end
      default: begin
        find_count++;
      end
    endcase
    reply.middle = (shadow_fill == 0) ? EMPTY_MIDDLE : shadow_cells[shadow_fill / 2];
    reply.count  = COUNT_W'(shadow_fill);
    return reply;
  endfunction

  // mostly random words, now and then an extreme
  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] val;
    case ($urandom_range(0, 15))
      0:       val = 32'sh8000_0000;
      1:       val = 32'sh7fff_ffff;
      2:       val = '0;
      3:       val = -32'sd1;
      default: val = $urandom;
    endcase
    return val;
  endfunction

  // one request transfer, then a random gap when the burst runs out
  task automatic send_request(input cmd_code_t cmd, input logic signed [VALUE_W-1:0] val);
    int gap;
    req_ch.valid      <= 1'b1;
    req_ch.command    <= cmd;
    req_ch.push_value <= val;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    expected_replies.push_back(predict_reply(cmd, val));
    sent_count++;
    if (sender_bursty) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // hold requests back until every reply is in
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  // empty stack refusals, extremes and deletes at counts two and one
  task automatic test_empty_stack();
    send_request(CMD_POP, $urandom);
    send_request(CMD_DELETE, $urandom);
    send_request(CMD_FIND, $urandom);
    send_request(CMD_PUSH, 32'sh8000_0000);
    send_request(CMD_FIND, $urandom);
    send_request(CMD_PUSH, 32'sh7fff_ffff);
    send_request(CMD_FIND, $urandom);
    send_request(CMD_DELETE, $urandom);
    send_request(CMD_DELETE, $urandom);
    send_request(CMD_POP, $urandom);
    send_request(CMD_DELETE, $urandom);
  endtask

  // fill to the top, then pushes that must be dropped
  task automatic test_fill_to_full();
    while (shadow_fill < STACK_DEPTH) send_request(CMD_PUSH, pick_value());
    send_request(CMD_FIND, $urandom);
    send_request(CMD_PUSH, 32'sh7fff_ffff);
    send_request(CMD_PUSH, '0);
  endtask

  // delete middle from a full stack and at odd and even counts
  task automatic test_delete_middle();
    send_request(CMD_DELETE, $urandom);
    send_request(CMD_FIND, $urandom);
    send_request(CMD_DELETE, $urandom);
    send_request(CMD_POP, $urandom);
    send_request(CMD_DELETE, $urandom);
    send_request(CMD_PUSH, -32'sd1);
    send_request(CMD_DELETE, $urandom);
  endtask

  // random traffic drifting between full and empty, with a stretch of gap-free requests
  task automatic test_random_traffic(input int item_total);
    fill_trend_t trend = TREND_MIXED;
    int          trend_left = 0;
    int          roll;
    cmd_code_t   cmd;
    for (int n = 0; n < item_total; n++) begin
      if (trend_left == 0) begin
        trend      = fill_trend_t'($urandom_range(0, 2));
        trend_left = $urandom_range(20, 120);
      end
      trend_left--;
      roll = $urandom_range(0, 99);
      case (trend)
        TREND_GROW:
          cmd = (roll < 55) ? CMD_PUSH : (roll < 65) ? CMD_POP :
                (roll < 80) ? CMD_FIND : CMD_DELETE;
        TREND_SHRINK:
          cmd = (roll < 20) ? CMD_PUSH : (roll < 55) ? CMD_POP :
                (roll < 65) ? CMD_FIND : CMD_DELETE;
        default:
          cmd = (roll < 25) ? CMD_PUSH : (roll < 50) ? CMD_POP :
                (roll < 75) ? CMD_FIND : CMD_DELETE;
      endcase
      // the sender holds off now and then until the block is drained
      if (n % 250 == 249) wait_drained();
      sender_bursty = !(n >= 400 && n < 550);
      send_request(cmd, pick_value());
    end
  endtask

  // receiver stalls on a pattern refreshed each time the phase counter wraps
  logic [15:0] stall_pattern = '0;
  logic [3:0]  stall_phase   = '0;

  always @(posedge clk) begin
    if (stall_phase == 4'd0) begin
      case ($urandom_range(0, 4))
        0, 1:    stall_pattern = 16'h0000;
        2:       stall_pattern = 16'($urandom & $urandom);
        3:       stall_pattern = 16'($urandom);
        default: stall_pattern = 16'(~($urandom & $urandom));
      endcase
    end
    rsp_ch.ready <= ~stall_pattern[stall_phase];
    stall_phase  <= stall_phase + 4'd1;
  end

  // compare each reply transfer with the oldest prediction
  always @(posedge clk) begin : check_reply
    stack_reply_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_replies.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("%0t: reply with none expected, expected nothing actual %0d/%0d/%0d",
                   $time, rsp_ch.middle_value, rsp_ch.entry_count, rsp_ch.op_status);
      end else begin
        want = expected_replies.pop_front();
        checked_count++;
        if (rsp_ch.middle_value !== want.middle) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("%0t: middle_value expected %0d actual %0d",
                     $time, want.middle, rsp_ch.middle_value);
        end
        if (rsp_ch.entry_count !== want.count) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, want.count, rsp_ch.entry_count);
        end
        if (rsp_ch.op_status !== want.status) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("%0t: op_status expected %0d actual %0d",
                     $time, want.status, rsp_ch.op_status);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // test sequence
  initial begin
    req_ch.valid      = 1'b0;
    req_ch.command    = CMD_FIND;
    req_ch.push_value = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_stack();
    wait_drained();
    test_fill_to_full();
    test_delete_middle();
    test_random_traffic(RANDOM_ITEMS);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_replies.size() != 0) begin
      error_count++;
      $display("%0t: %0d replies expected but never seen", $time, expected_replies.size());
    end
    $display("covered %0d requests: %0d push, %0d pop, %0d find, %0d delete; %0d replies checked",
             sent_count, push_count, pop_count, find_count, delete_count, checked_count);
    $display("%0d pushes refused when full, %0d pops or deletes refused when empty, %0d errors",
             full_drops, empty_ignores, error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
